FILE: hdl/gpw_pkg.sv
// shared types, codes and register defaults for the goal progress watchdog
`timescale 1ns / 1ps

package gpw_pkg;

	localparam int DIST_W = 24;
	localparam int TIME_W = 32;
	localparam int HEAD_W = 16;
	localparam int TURN_W = 20;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	// configuration port geometry
	localparam int CFG_DW  = 32;
	localparam int CFG_AW  = 5;
	localparam int CFG_IW  = CFG_AW - 2;

	// item opcodes
	localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
	localparam logic [OP_W-1:0] OP_WAYPOINT  = 2'd1;
	localparam logic [OP_W-1:0] OP_END_KEEP  = 2'd2;
	localparam logic [OP_W-1:0] OP_END_RESET = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_IDLE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_STALLED = 2'd1;
	localparam logic [STAT_W-1:0] ST_ORBIT   = 2'd2;
	localparam logic [STAT_W-1:0] ST_CLEAR   = 2'd3;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_STALL_WINDOW = 3'd0;
	localparam logic [CFG_IW-1:0] REG_STALL_MARGIN = 3'd1;
	localparam logic [CFG_IW-1:0] REG_STALL_IGNORE = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ORBIT_LIMIT  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ORBIT_MARGIN = 3'd4;
	localparam logic [CFG_IW-1:0] REG_ORBIT_IGNORE = 3'd5;

	// register reset values
	localparam logic [TIME_W-1:0] RST_STALL_WINDOW = 32'd20000;
	localparam logic [DIST_W-1:0] RST_STALL_MARGIN = 24'd150;
	localparam logic [DIST_W-1:0] RST_STALL_IGNORE = 24'd250;
	localparam logic [TURN_W-1:0] RST_ORBIT_LIMIT  = 20'd49152;
	localparam logic [DIST_W-1:0] RST_ORBIT_MARGIN = 24'd300;
	localparam logic [DIST_W-1:0] RST_ORBIT_IGNORE = 24'd300;

	localparam logic [DIST_W-1:0] DIST_UNSET = '1;
	localparam logic [HEAD_W-1:0] HALF_TURN  = 16'h8000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DIST_W-1:0] goal_distance;
		logic [HEAD_W-1:0] heading;
		logic [TIME_W-1:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DIST_W-1:0] best_distance;
		logic [TIME_W-1:0] time_since_gain;
		logic [TURN_W-1:0] turn_total;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] stall_window_ms;
		logic [DIST_W-1:0] stall_margin_mm;
		logic [DIST_W-1:0] stall_ignore_mm;
		logic [TURN_W-1:0] orbit_turn_limit;
		logic [DIST_W-1:0] orbit_margin_mm;
		logic [DIST_W-1:0] orbit_ignore_mm;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic update;
	} det_ctrl_t;

endpackage

FILE: hdl/goal_progress_watchdog_unit.sv
// top level of the goal progress watchdog
`timescale 1ns / 1ps

// Takes one beat per cycle on the sample channel while the result side is not
// stalled and returns exactly one result beat for each, in order, on the result
// port: the beat is captured in an input register, the stall and orbit
// detectors work out their next state from it combinationally and the outcome
// lands in the result register as that state is stored. The read-modify-write
// of the detector state, done as the item leaves the input register, sets the
// rate of one item per clock. A new beat is taken while a result waits, as long
// as the input register is free or moving on. Configuration registers are read
// and written through the apb-style port at any time, but should only be
// changed while no beat is in flight.
module goal_progress_watchdog_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gpw_pkg::CFG_AW-1:0] paddr,
	input  logic [gpw_pkg::CFG_DW-1:0] pwdata,
	output logic [gpw_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  gpw_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output gpw_pkg::result_t           result
);
	import gpw_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	sample_t   item_s1;
	logic      res_valid_q;
	result_t   res_q;
	logic      has_goal_q, has_goal_n;
	logic      advance;
	logic      out_free;
	det_ctrl_t stall_ctrl, orbit_ctrl;

	logic [DIST_W-1:0] best_next;
	logic [TIME_W-1:0] since_next;
	logic              stall_flag_next;
	logic [TURN_W-1:0] turn_next;
	logic              orbit_flag_next;
	logic [STAT_W-1:0] status_next;
	logic              is_clear_op;

	assign pready = 1'b1;

	gpw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign out_free     = !res_valid_q || result_ready;
	assign advance      = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || out_free;

	assign is_clear_op = (item_s1.op == OP_WAYPOINT) || (item_s1.op == OP_END_RESET);

	assign stall_ctrl.clear  = advance && is_clear_op;
	assign stall_ctrl.update = advance && (item_s1.op == OP_SAMPLE) && has_goal_q;
	// orbit side is frozen while the stall detector is firing
	assign orbit_ctrl.clear  = stall_ctrl.clear;
	assign orbit_ctrl.update = stall_ctrl.update && !stall_flag_next;

	gpw_stall u_stall (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (stall_ctrl),
		.cfg        (cfg),
		.dist_mm    (item_s1.goal_distance),
		.time_ms    (item_s1.time_ms),
		.best_next  (best_next),
		.since_next (since_next),
		.flag_next  (stall_flag_next)
	);

	gpw_orbit u_orbit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (orbit_ctrl),
		.cfg       (cfg),
		.dist_mm   (item_s1.goal_distance),
		.heading   (item_s1.heading),
		.turn_next (turn_next),
		.flag_next (orbit_flag_next)
	);

	always_comb begin
		has_goal_n = has_goal_q;
		if (advance) begin
			unique case (item_s1.op)
				OP_WAYPOINT:               has_goal_n = 1'b1;
				OP_END_KEEP, OP_END_RESET: has_goal_n = 1'b0;
				default:                   has_goal_n = has_goal_q;
			endcase
		end
	end

	always_comb begin
		if (!has_goal_n) begin
			status_next = ST_IDLE;
		end else if (stall_flag_next) begin
			status_next = ST_STALLED;
		end else if (orbit_flag_next) begin
			status_next = ST_ORBIT;
		end else begin
			status_next = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			has_goal_q  <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			has_goal_q <= has_goal_n;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample;
		end
		if (advance) begin
			res_q.status          <= status_next;
			res_q.best_distance   <= best_next;
			res_q.time_since_gain <= since_next;
			res_q.turn_total      <= turn_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: hdl/gpw_cfg.sv
// configuration register bank behind the apb-style port
`timescale 1ns / 1ps

module gpw_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gpw_pkg::CFG_AW-1:0] paddr,
	input  logic [gpw_pkg::CFG_DW-1:0] pwdata,
	output logic [gpw_pkg::CFG_DW-1:0] prdata,
	output gpw_pkg::cfg_t              cfg
);
	import gpw_pkg::*;

	logic [CFG_IW-1:0] idx;
	logic              wr_en;
	cfg_t              cfg_q;

	assign idx   = paddr[CFG_AW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_window_ms  <= RST_STALL_WINDOW;
			cfg_q.stall_margin_mm  <= RST_STALL_MARGIN;
			cfg_q.stall_ignore_mm  <= RST_STALL_IGNORE;
			cfg_q.orbit_turn_limit <= RST_ORBIT_LIMIT;
			cfg_q.orbit_margin_mm  <= RST_ORBIT_MARGIN;
			cfg_q.orbit_ignore_mm  <= RST_ORBIT_IGNORE;
		end else if (wr_en) begin
			unique case (idx)
				REG_STALL_WINDOW: cfg_q.stall_window_ms  <= pwdata[TIME_W-1:0];
				REG_STALL_MARGIN: cfg_q.stall_margin_mm  <= pwdata[DIST_W-1:0];
				REG_STALL_IGNORE: cfg_q.stall_ignore_mm  <= pwdata[DIST_W-1:0];
				REG_ORBIT_LIMIT:  cfg_q.orbit_turn_limit <= pwdata[TURN_W-1:0];
				REG_ORBIT_MARGIN: cfg_q.orbit_margin_mm  <= pwdata[DIST_W-1:0];
				REG_ORBIT_IGNORE: cfg_q.orbit_ignore_mm  <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_STALL_WINDOW: prdata = cfg_q.stall_window_ms;
			REG_STALL_MARGIN: prdata = {{(CFG_DW-DIST_W){1'b0}}, cfg_q.stall_margin_mm};
			REG_STALL_IGNORE: prdata = {{(CFG_DW-DIST_W){1'b0}}, cfg_q.stall_ignore_mm};
			REG_ORBIT_LIMIT:  prdata = {{(CFG_DW-TURN_W){1'b0}}, cfg_q.orbit_turn_limit};
			REG_ORBIT_MARGIN: prdata = {{(CFG_DW-DIST_W){1'b0}}, cfg_q.orbit_margin_mm};
			REG_ORBIT_IGNORE: prdata = {{(CFG_DW-DIST_W){1'b0}}, cfg_q.orbit_ignore_mm};
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: hdl/gpw_stall.sv
// stall detector: best distance, time of last gain and stall flag
`timescale 1ns / 1ps

module gpw_stall (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gpw_pkg::det_ctrl_t         ctrl,
	input  gpw_pkg::cfg_t              cfg,
	input  logic [gpw_pkg::DIST_W-1:0] dist_mm,
	input  logic [gpw_pkg::TIME_W-1:0] time_ms,
	output logic [gpw_pkg::DIST_W-1:0] best_next,
	output logic [gpw_pkg::TIME_W-1:0] since_next,
	output logic                       flag_next
);
	import gpw_pkg::*;

	logic              primed_q, primed_n;
	logic [DIST_W-1:0] best_q,   best_n;
	logic [TIME_W-1:0] gain_q,   gain_n;
	logic [TIME_W-1:0] since_q,  since_n;
	logic              flag_q,   flag_n;

	always_comb begin
		primed_n = primed_q;
		best_n   = best_q;
		gain_n   = gain_q;
		since_n  = since_q;
		flag_n   = flag_q;
		if (ctrl.clear || (ctrl.update && dist_mm < cfg.stall_ignore_mm)) begin
			primed_n = 1'b0;
			best_n   = DIST_UNSET;
			gain_n   = '0;
			since_n  = '0;
			flag_n   = 1'b0;
		end else if (ctrl.update) begin
			if (!primed_q) begin
				// first sample outside the ignore radius starts the clock
				primed_n = 1'b1;
				best_n   = dist_mm;
				gain_n   = time_ms;
				flag_n   = 1'b0;
			end else begin
				if (best_q >= cfg.stall_margin_mm &&
				    dist_mm < best_q - cfg.stall_margin_mm) begin
					best_n = dist_mm;
					gain_n = time_ms;
				end
				// wraps modulo 2^32 with the timestamp
				since_n = time_ms - gain_n;
				flag_n  = since_n > cfg.stall_window_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			best_q   <= DIST_UNSET;
			gain_q   <= '0;
			since_q  <= '0;
			flag_q   <= 1'b0;
		end else begin
			primed_q <= primed_n;
			best_q   <= best_n;
			gain_q   <= gain_n;
			since_q  <= since_n;
			flag_q   <= flag_n;
		end
	end

	assign best_next  = best_n;
	assign since_next = since_n;
	assign flag_next  = flag_n;

endmodule

FILE: hdl/gpw_orbit.sv
// orbit detector: saturating sum of heading change, cleared on progress
`timescale 1ns / 1ps

module gpw_orbit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gpw_pkg::det_ctrl_t         ctrl,
	input  gpw_pkg::cfg_t              cfg,
	input  logic [gpw_pkg::DIST_W-1:0] dist_mm,
	input  logic [gpw_pkg::HEAD_W-1:0] heading,
	output logic [gpw_pkg::TURN_W-1:0] turn_next,
	output logic                       flag_next
);
	import gpw_pkg::*;

	logic              primed_q, primed_n;
	logic [HEAD_W-1:0] last_q,   last_n;
	logic [TURN_W-1:0] turn_q,   turn_n;
	logic [DIST_W-1:0] best_q,   best_n;
	logic              flag_q,   flag_n;

	logic [HEAD_W-1:0] diff;
	logic [HEAD_W-1:0] step;
	logic [TURN_W:0]   sum;
	logic [TURN_W-1:0] accum;
	logic              gained;

	assign diff   = heading - last_q;
	// shortest way round; a half turn counts as a half turn
	assign step   = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;
	assign sum    = {1'b0, turn_q} + {{(TURN_W+1-HEAD_W){1'b0}}, step};
	assign gained = (best_q > dist_mm) && ((best_q - dist_mm) > cfg.orbit_margin_mm);

	always_comb begin
		primed_n = primed_q;
		last_n   = last_q;
		turn_n   = turn_q;
		best_n   = best_q;
		flag_n   = flag_q;
		accum    = sum[TURN_W] ? {TURN_W{1'b1}} : sum[TURN_W-1:0];
		if (ctrl.clear || (ctrl.update && dist_mm < cfg.orbit_ignore_mm)) begin
			primed_n = 1'b0;
			turn_n   = '0;
			best_n   = DIST_UNSET;
			flag_n   = 1'b0;
		end else if (ctrl.update) begin
			flag_n = 1'b0;
			last_n = heading;
			if (!primed_q) begin
				primed_n = 1'b1;
			end else begin
				if (dist_mm < best_q) begin
					best_n = dist_mm;
				end
				if (gained) begin
					accum = '0;
				end
				turn_n = accum;
				flag_n = accum > cfg.orbit_turn_limit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			last_q   <= '0;
			turn_q   <= '0;
			best_q   <= DIST_UNSET;
			flag_q   <= 1'b0;
		end else begin
			primed_q <= primed_n;
			last_q   <= last_n;
			turn_q   <= turn_n;
			best_q   <= best_n;
			flag_q   <= flag_n;
		end
	end

	assign turn_next = turn_n;
	assign flag_next = flag_n;

endmodule

FILE: hdl/gpw_checker.sv
// port-level checks for the goal progress watchdog, bound to the top level
`timescale 1ns / 1ps

module gpw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_ready,
	input logic             result_valid,
	input logic             result_ready,
	input gpw_pkg::result_t result
);
	import gpw_pkg::*;

	// a held result beat keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// input side only backs up behind a waiting result
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("sample side stalled with no result waiting");

	// stall only fires after some time without gain
	a_stall_time: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_STALLED |-> result.time_since_gain != '0)
		else $error("stall reported with zero time since gain");

	// orbit only fires with a nonzero heading sum
	a_orbit_turn: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_ORBIT |-> result.turn_total != '0)
		else $error("orbit reported with zero heading sum");

endmodule

bind goal_progress_watchdog_unit gpw_checker u_gpw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
